// ===== src/ordered_array_insert_delete_core_defines.svh =====
// Assertion macros shared by the ordered array core.
`ifndef ORDERED_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OAID_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OAID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/oaid_pkg.sv =====
// Types and constants shared by the ordered array core and its submodules.
package oaid_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 6;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int ENTRY_IDX_W = 5;
  localparam int FILL_W = 6;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_VIEW   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } st_e;

  typedef struct packed {
    op_e                      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    st_e                       status;
    logic [ENTRY_IDX_W-1:0]    entry_index;
    logic signed [DATA_W-1:0]  entry_value;
    logic [FILL_W-1:0]         fill_count;
    logic                      last;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

// ===== src/ordered_array_insert_delete_core.sv =====
// Ordered array core: insert, update, delete and view over a register array.
// Insert, update and delete run the accept cycle and then one execute step, which shifts the
// whole array for insert and delete; the result word is strobed in the cycle after the step.
// A view of N entries gives one result word per cycle after the accept cycle.
// The execute step of the controller sets this rate; the next item may start as a result shows.
// Reset is asynchronous, active low; it empties the array, and entry contents need no reset.
`include "ordered_array_insert_delete_core_defines.svh"

module ordered_array_insert_delete_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  oaid_pkg::in_t   in_i,
  output logic            res_valid_o,
  output oaid_pkg::out_t  res_o
);

  oaid_pkg::ctrl_cmd_t cmd;
  oaid_pkg::dp_stat_t  stat;

  oaid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .res_valid_o (res_valid_o)
  );

  oaid_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

  `OAID_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy,
    "Accepted word did not make the core busy.")
  `OAID_ASSERT_SAME(a_view_continues, clk_i, rst_ni, res_valid_o && !res_o.last, busy,
    "A result without the last mark was not followed by further work.")
  `OAID_ASSERT_SAME(a_error_is_last, clk_i, rst_ni,
    res_valid_o && (res_o.status != oaid_pkg::ST_OK), res_o.last,
    "An error status was not the final result word.")
  `OAID_ASSERT_SAME(a_empty_count, clk_i, rst_ni,
    res_valid_o && (res_o.status == oaid_pkg::ST_EMPTY), res_o.fill_count == '0,
    "Empty status reported with a nonzero fill count.")

endmodule

// ===== src/oaid_ctrl.sv =====
// Sequencing state machine of the ordered array core.
module oaid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  oaid_pkg::dp_stat_t   stat_i,
  output oaid_pkg::ctrl_cmd_t  cmd_o,
  output logic                 res_valid_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_VIEW
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;

  always_comb begin
    state_d     = state_q;
    res_valid_d = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC, S_VIEW: begin
        // Each step produces one result word; a view keeps stepping while entries remain.
        cmd_o.step  = 1'b1;
        res_valid_d = 1'b1;
        state_d     = stat_i.more ? S_VIEW : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;

endmodule

// ===== src/oaid_dpath.sv =====
// Entry register array, fill count and result register of the ordered array core.
module oaid_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  oaid_pkg::in_t        in_i,
  input  oaid_pkg::ctrl_cmd_t  cmd_i,
  output oaid_pkg::dp_stat_t   stat_o,
  output oaid_pkg::out_t       res_o
);

  localparam int Depth = oaid_pkg::DEPTH;
  localparam int IdxW  = oaid_pkg::IDX_W;
  localparam int CntW  = oaid_pkg::CNT_W;
  localparam int CmpW  = oaid_pkg::CMP_W;
  localparam int DataW = oaid_pkg::DATA_W;

  oaid_pkg::in_t   cmd_q;
  oaid_pkg::out_t  res_q, res_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] view_idx_q;
  logic [DataW-1:0] entries_q [Depth];
  logic [DataW-1:0] entries_d [Depth];

  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            is_view, view_last;
  logic            ins_ok, upd_ok, del_ok;

  assign pos_ext = CmpW'(cmd_q.position);
  assign cnt_ext = CmpW'(count_q);
  assign is_view = (cmd_q.opcode == oaid_pkg::OP_VIEW);
  assign view_last = ((CntW'(view_idx_q) + CntW'(1)) == count_q);

  assign ins_ok = (cmd_q.opcode == oaid_pkg::OP_INSERT) && (pos_ext <= cnt_ext)
                  && (cnt_ext < CmpW'(Depth));
  assign upd_ok = (cmd_q.opcode == oaid_pkg::OP_UPDATE) && (pos_ext < cnt_ext);
  assign del_ok = (cmd_q.opcode == oaid_pkg::OP_DELETE) && (pos_ext < cnt_ext);

  assign stat_o.more = is_view && (count_q != '0) && !view_last;

  // Every entry picks its own next value, so a whole shift happens in one step.
  for (genvar i = 0; i < Depth; i++) begin : g_entry
    logic [DataW-1:0] below, above;
    logic [CmpW-1:0]  ic;
    assign ic = CmpW'(i);
    if (i > 0) begin : g_below
      assign below = entries_q[i-1];
    end else begin : g_no_below
      assign below = entries_q[i];
    end
    if (i < Depth - 1) begin : g_above
      assign above = entries_q[i+1];
    end else begin : g_no_above
      assign above = entries_q[i];
    end

    always_comb begin
      entries_d[i] = entries_q[i];
      if (ins_ok) begin
        if (ic == pos_ext) begin
          entries_d[i] = cmd_q.value;
        end else if ((ic > pos_ext) && (ic <= cnt_ext)) begin
          entries_d[i] = below;
        end
      end else if (upd_ok) begin
        if (ic == pos_ext) begin
          entries_d[i] = cmd_q.value;
        end
      end else if (del_ok) begin
        if ((ic >= pos_ext) && ((ic + CmpW'(1)) < cnt_ext)) begin
          entries_d[i] = above;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.step) begin
        entries_q[i] <= entries_d[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    res_d   = '0;
    res_d.last = 1'b1;
    case (cmd_q.opcode)
      oaid_pkg::OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          res_d.status = oaid_pkg::ST_BADPOS;
        end else if (!ins_ok) begin
          res_d.status = oaid_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      oaid_pkg::OP_UPDATE: begin
        if (!upd_ok) begin
          res_d.status = oaid_pkg::ST_BADPOS;
        end
      end
      oaid_pkg::OP_DELETE: begin
        if (!del_ok) begin
          res_d.status = oaid_pkg::ST_BADPOS;
        end else begin
          count_d = count_q - CntW'(1);
        end
      end
      oaid_pkg::OP_VIEW: begin
        if (count_q == '0) begin
          res_d.status = oaid_pkg::ST_EMPTY;
        end else begin
          res_d.entry_index = oaid_pkg::ENTRY_IDX_W'(view_idx_q);
          res_d.entry_value = entries_q[view_idx_q];
          res_d.last        = view_last;
        end
      end
      default: begin
        res_d.status = oaid_pkg::ST_BADPOS;
      end
    endcase
    res_d.fill_count = oaid_pkg::FILL_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      view_idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        view_idx_q <= '0;
      end else if (cmd_i.step) begin
        count_q    <= count_d;
        view_idx_q <= view_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= in_i;
    end
    if (cmd_i.step) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
